@@ hw/rtl/set_assoc_cache_lru_sim_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the cache directory simulator
// Shared concurrent assertion wrappers, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_LRU_SIM_DEFINES_SVH
`define SET_ASSOC_CACHE_LRU_SIM_DEFINES_SVH

// Checked only while the block is out of reset.
`define SACL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, including those with reset asserted.
`define SACL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/sacl_pkg.sv @@
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared constants, codes and control types of the cache directory simulator.
// ----------------------------------------------------------------------------
package sacl_pkg;

  // Default structural sizes.
  localparam int MAX_SET_BITS_DEF = 6;
  localparam int MAX_WAYS_DEF     = 8;
  localparam int ADDR_WIDTH_DEF   = 64;

  // Fixed field widths.
  localparam int CMD_W     = 2;
  localparam int OUTCOME_W = 2;
  localparam int CNT_W     = 32;
  localparam int DATA_W    = 32;
  localparam int PADDR_W   = 4;
  localparam int IN_ADDR_W = 64;

  // Access commands.
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STORE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd2;

  // Outcome of the first access.
  localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_FILL  = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_EVICT = 2'd2;

  // Register indexes (byte address = 4 * index).
  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS       = 2'd2;

  // Register reset values.
  localparam logic [2:0] SET_BITS_RST   = 3'd4;
  localparam logic [4:0] BLOCK_BITS_RST = 5'd4;
  localparam logic [3:0] WAYS_RST       = 4'd1;

  // Configuration after clamping to the built sizes.
  typedef struct packed {
    logic [3:0] sb;   // set index bits in use
    logic [4:0] bb;   // offset bits dropped
    logic [4:0] nw;   // ways in use, 1..MAX_WAYS
  } cfg_eff_t;

  // Per-transaction status from the lookup logic.
  typedef struct packed {
    logic [OUTCOME_W-1:0] outcome;
    logic                 second_hit;
    logic [1:0]           hit_inc;
    logic                 miss_inc;
    logic                 evict_inc;
  } lk_status_t;

endpackage

@@ hw/rtl/sacl_ram.sv @@
// ----------------------------------------------------------------------------
// sacl_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

@@ hw/rtl/sacl_cfg.sv @@
// ----------------------------------------------------------------------------
// sacl_cfg
// APB register file for set_bits, block_bits and ways, with clamped outputs.
// ----------------------------------------------------------------------------
module sacl_cfg #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sacl_pkg::PADDR_W-1:0]   paddr,
  input  logic [sacl_pkg::DATA_W-1:0]    pwdata,
  output logic [sacl_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  output sacl_pkg::cfg_eff_t             cfg_eff
);
  import sacl_pkg::*;

  logic [2:0] set_bits_r;
  logic [4:0] block_bits_r;
  logic [3:0] ways_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= SET_BITS_RST;
      block_bits_r <= BLOCK_BITS_RST;
      ways_r       <= WAYS_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_SET_BITS:   set_bits_r   <= pwdata[2:0];
        REG_BLOCK_BITS: block_bits_r <= pwdata[4:0];
        REG_WAYS:       ways_r       <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SET_BITS:   prdata = DATA_W'(set_bits_r);
      REG_BLOCK_BITS: prdata = DATA_W'(block_bits_r);
      REG_WAYS:       prdata = DATA_W'(ways_r);
      default:        prdata = '0;
    endcase
  end

  // Out-of-range values act as the nearest supported setting.
  always_comb begin
    cfg_eff.bb = block_bits_r;
    if ({1'b0, set_bits_r} > 4'(MAX_SET_BITS)) begin
      cfg_eff.sb = 4'(MAX_SET_BITS);
    end else begin
      cfg_eff.sb = {1'b0, set_bits_r};
    end
    if (ways_r == 4'd0) begin
      cfg_eff.nw = 5'd1;
    end else if ({1'b0, ways_r} > 5'(MAX_WAYS)) begin
      cfg_eff.nw = 5'(MAX_WAYS);
    end else begin
      cfg_eff.nw = {1'b0, ways_r};
    end
  end

endmodule

@@ hw/rtl/sacl_lookup.sv @@
// ----------------------------------------------------------------------------
// sacl_lookup
// Tag compare, fill/victim choice and LRU rank update for one set row.
// ----------------------------------------------------------------------------
module sacl_lookup #(
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_WIDTH = 64,
  localparam int AGE_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  localparam int WAY_W = 1 + AGE_W + ADDR_WIDTH,
  localparam int ROW_W = MAX_WAYS * WAY_W
) (
  input  sacl_pkg::cfg_eff_t            cfg_eff,
  input  logic [sacl_pkg::CMD_W-1:0]    cmd,
  input  logic [ADDR_WIDTH-1:0]         addr,
  input  logic [ROW_W-1:0]              row_in,
  output logic [ROW_W-1:0]              row_out,
  output sacl_pkg::lk_status_t          status
);
  import sacl_pkg::*;

  localparam int WIDX_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam logic [AGE_W-1:0] AGE_CAP  = AGE_W'(MAX_WAYS - 1);
  localparam logic [AGE_W:0]   AGE_FILL = (AGE_W + 1)'(MAX_WAYS);

  logic [5:0]            shamt;
  logic [ADDR_WIDTH-1:0] tag;
  logic [MAX_WAYS-1:0]   way_valid;
  logic [MAX_WAYS-1:0]   in_use;
  logic [MAX_WAYS-1:0]   hit_vec;
  logic [MAX_WAYS-1:0]   free_vec;
  logic [AGE_W-1:0]      way_age [MAX_WAYS];
  logic [ADDR_WIDTH-1:0] way_tag [MAX_WAYS];
  logic                  hit_any;
  logic                  free_any;
  logic [WIDX_W-1:0]     hit_way;
  logic [WIDX_W-1:0]     free_way;
  logic [WIDX_W-1:0]     victim;
  logic [AGE_W-1:0]      best;
  logic [WIDX_W-1:0]     sel;
  logic [AGE_W:0]        old_rank;
  logic                  is_mod;

  // Unpack the row; each way is {valid, rank, tag}.
  always_comb begin
    shamt = 6'(cfg_eff.bb) + 6'(cfg_eff.sb);
    tag   = addr >> shamt;
    for (int w = 0; w < MAX_WAYS; w++) begin
      way_tag[w]   = row_in[w*WAY_W +: ADDR_WIDTH];
      way_age[w]   = row_in[w*WAY_W + ADDR_WIDTH +: AGE_W];
      way_valid[w] = row_in[w*WAY_W + WAY_W - 1];
      in_use[w]    = (w < int'(cfg_eff.nw));
      hit_vec[w]   = in_use[w] & way_valid[w] & (way_tag[w] == tag);
      free_vec[w]  = in_use[w] & ~way_valid[w];
    end
  end

  // Lowest matching way and lowest free way.
  always_comb begin
    hit_any  = |hit_vec;
    free_any = |free_vec;
    hit_way  = '0;
    free_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WIDX_W'(w);
      end
      if (free_vec[w]) begin
        free_way = WIDX_W'(w);
      end
    end
  end

  // Victim: oldest valid way in use, ties to the lowest index.
  always_comb begin
    best   = '0;
    victim = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (in_use[w] && way_valid[w] && (w == 0 || way_age[w] > best)) begin
        best   = way_age[w];
        victim = WIDX_W'(w);
      end
    end
  end

  always_comb begin
    if (hit_any) begin
      sel      = hit_way;
      old_rank = {1'b0, way_age[hit_way]};
    end else if (free_any) begin
      sel      = free_way;
      old_rank = AGE_FILL;
    end else begin
      sel      = victim;
      old_rank = {1'b0, way_age[victim]};
    end
  end

  // The chosen way becomes most recent; younger valid ways age by one.
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      row_out[w*WAY_W +: WAY_W] = row_in[w*WAY_W +: WAY_W];
      if (WIDX_W'(w) == sel) begin
        row_out[w*WAY_W +: WAY_W] = {1'b1, {AGE_W{1'b0}}, tag};
      end else if (in_use[w] && way_valid[w] && ({1'b0, way_age[w]} < old_rank) &&
                   (way_age[w] < AGE_CAP)) begin
        row_out[w*WAY_W + ADDR_WIDTH +: AGE_W] = way_age[w] + 1'b1;
      end
    end
  end

  // A modify repeats the access on a line that is now most recent, so the
  // second access hits and leaves the row as it is.
  always_comb begin
    case (cmd)
      CMD_LOAD, CMD_STORE: is_mod = 1'b0;
      CMD_MODIFY:          is_mod = 1'b1;
      default:             is_mod = 1'b0;
    endcase
    if (hit_any) begin
      status.outcome = OUT_HIT;
    end else if (free_any) begin
      status.outcome = OUT_FILL;
    end else begin
      status.outcome = OUT_EVICT;
    end
    status.second_hit = is_mod;
    status.hit_inc    = 2'(hit_any) + 2'(is_mod);
    status.miss_inc   = ~hit_any;
    status.evict_inc  = ~hit_any & ~free_any;
  end

endmodule

@@ hw/rtl/set_assoc_cache_lru_sim.sv @@
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim
// Tag-only set-associative cache directory with true LRU replacement.
//
// Usage: an access transaction (in_command, in_mem_address) enters on the
// in_valid/in_ready channel. One result transaction per access leaves on the
// out_valid/out_ready channel: the outcome of the first access, the second
// hit flag of a modify, and the saturating hit, miss and eviction totals.
// The edge that accepts the access reads the set's row from the directory
// memory, and the edge on which the access stage advances writes the updated
// row back and loads the result register. While out_ready stays high, one
// access per cycle is sustained, also to the same set, because the row just
// written is forwarded to the following access. The single read and single
// write port of the set memory set this rate.
// When out_ready is low the result register holds, the access behind it
// waits in its stage, and in_ready drops only when both are occupied.
// Reset (rst_n low, synchronous) empties the pipeline, clears the totals,
// restores the register defaults and marks every set row empty at once, so
// no clearing pass is needed. The user must write registers over the APB
// port only while no transaction is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "set_assoc_cache_lru_sim_defines.svh"

module set_assoc_cache_lru_sim #(
  parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = sacl_pkg::MAX_WAYS_DEF,
  parameter int ADDR_WIDTH   = sacl_pkg::ADDR_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Access channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [sacl_pkg::CMD_W-1:0]         in_command,
  input  logic [sacl_pkg::IN_ADDR_W-1:0]     in_mem_address,
  // Result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [sacl_pkg::OUTCOME_W-1:0]     out_outcome,
  output logic                               out_second_hit,
  output logic [sacl_pkg::CNT_W-1:0]         out_hit_total,
  output logic [sacl_pkg::CNT_W-1:0]         out_miss_total,
  output logic [sacl_pkg::CNT_W-1:0]         out_eviction_total,
  // Configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sacl_pkg::PADDR_W-1:0]       paddr,
  input  logic [sacl_pkg::DATA_W-1:0]        pwdata,
  output logic [sacl_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);
  import sacl_pkg::*;

  localparam int SETS  = 1 << MAX_SET_BITS;
  localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int AGE_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_W = 1 + AGE_W + ADDR_WIDTH;
  localparam int ROW_W = MAX_WAYS * WAY_W;

  cfg_eff_t              cfg_eff;
  lk_status_t            lk_status;

  logic [ADDR_WIDTH-1:0] in_addr;
  logic [ADDR_WIDTH-1:0] set_shift;
  logic [SET_W-1:0]      set_mask;
  logic [SET_W-1:0]      rd_set;
  logic                  in_fire;
  logic                  adv;

  // Access stage: transaction waiting on its row read.
  logic                  s1_valid_r;
  logic [CMD_W-1:0]      s1_cmd_r;
  logic [ADDR_WIDTH-1:0] s1_addr_r;
  logic [SET_W-1:0]      s1_set_r;
  logic                  s1_rowv_r;
  logic                  s1_byp_r;
  logic [ROW_W-1:0]      byp_row_r;

  logic [SETS-1:0]       row_valid_r;
  logic [ROW_W-1:0]      ram_rdata;
  logic [ROW_W-1:0]      row_cur;
  logic [ROW_W-1:0]      row_new;

  // Result register and running totals.
  logic                  out_valid_r;
  logic [OUTCOME_W-1:0]  out_outcome_r;
  logic                  out_second_hit_r;
  logic [CNT_W-1:0]      hit_cnt_r;
  logic [CNT_W-1:0]      miss_cnt_r;
  logic [CNT_W-1:0]      evict_cnt_r;
  logic [CNT_W:0]        hit_sum;
  logic [CNT_W:0]        miss_sum;
  logic [CNT_W:0]        evict_sum;
  logic [CNT_W-1:0]      hit_cnt_nxt;
  logic [CNT_W-1:0]      miss_cnt_nxt;
  logic [CNT_W-1:0]      evict_cnt_nxt;

  sacl_cfg #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_eff (cfg_eff)
  );

  // Set index from the incoming address, used as the row read address.
  assign in_addr   = in_mem_address[ADDR_WIDTH-1:0];
  assign set_shift = in_addr >> cfg_eff.bb;
  assign set_mask  = ~({SET_W{1'b1}} << cfg_eff.sb);
  assign rd_set    = set_shift[SET_W-1:0] & set_mask;

  // The stage moves on when the result register is free or being emptied.
  assign adv      = s1_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~s1_valid_r | adv;
  assign in_fire  = in_valid & in_ready;

  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_dir_ram (
    .clk   (clk),
    .we    (adv),
    .waddr (s1_set_r),
    .wdata (row_new),
    .re    (in_fire),
    .raddr (rd_set),
    .rdata (ram_rdata)
  );

  // A row written in the same cycle it was read is taken from the forward
  // register; a row never written since reset reads as empty.
  always_comb begin
    if (s1_byp_r) begin
      row_cur = byp_row_r;
    end else if (s1_rowv_r) begin
      row_cur = ram_rdata;
    end else begin
      row_cur = '0;
    end
  end

  sacl_lookup #(
    .MAX_WAYS   (MAX_WAYS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_lookup (
    .cfg_eff (cfg_eff),
    .cmd     (s1_cmd_r),
    .addr    (s1_addr_r),
    .row_in  (row_cur),
    .row_out (row_new),
    .status  (lk_status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      row_valid_r <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        row_valid_r[s1_set_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r  <= in_command;
      s1_addr_r <= in_addr;
      s1_set_r  <= rd_set;
      s1_rowv_r <= row_valid_r[rd_set];
      s1_byp_r  <= adv & (rd_set == s1_set_r);
      byp_row_r <= row_new;
    end
  end

  // Saturating totals.
  always_comb begin
    hit_sum   = {1'b0, hit_cnt_r} + (CNT_W + 1)'(lk_status.hit_inc);
    miss_sum  = {1'b0, miss_cnt_r} + (CNT_W + 1)'(lk_status.miss_inc);
    evict_sum = {1'b0, evict_cnt_r} + (CNT_W + 1)'(lk_status.evict_inc);
    hit_cnt_nxt   = hit_sum[CNT_W] ? {CNT_W{1'b1}} : hit_sum[CNT_W-1:0];
    miss_cnt_nxt  = miss_sum[CNT_W] ? {CNT_W{1'b1}} : miss_sum[CNT_W-1:0];
    evict_cnt_nxt = evict_sum[CNT_W] ? {CNT_W{1'b1}} : evict_sum[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      evict_cnt_r <= evict_cnt_nxt;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_outcome_r    <= lk_status.outcome;
      out_second_hit_r <= lk_status.second_hit;
    end
  end

  // Totals change only when a result is loaded, so they double as payload.
  assign out_valid          = out_valid_r;
  assign out_outcome        = out_outcome_r;
  assign out_second_hit     = out_second_hit_r;
  assign out_hit_total      = hit_cnt_r;
  assign out_miss_total     = miss_cnt_r;
  assign out_eviction_total = evict_cnt_r;

  `SACL_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!s1_valid_r && !out_valid_r), "pipeline not empty after reset")
  `SACL_ASSERT(a_adv_loads_out, adv |=> out_valid_r, "advanced transaction produced no result")
  `SACL_ASSERT(a_fwd_same_set, (in_fire && adv && (rd_set == s1_set_r)) |=> s1_byp_r, "same-set row not forwarded")
  `SACL_ASSERT(a_second_hit_mod, (adv && (s1_cmd_r != CMD_MODIFY)) |-> !lk_status.second_hit, "second hit without modify")
  `SACL_ASSERT(a_hit_monotonic, $past(rst_n) |-> (hit_cnt_r >= $past(hit_cnt_r)), "hit total decreased")

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench of the set-associative cache directory simulator
// Sends load, store, modify and reserved-command accesses under a range of
// set, block and way settings. A scoreboard keeps its own directory with true
// LRU ranking and checks every result transaction, field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sacl_pkg::*;

  // Sizes of the directory as the block is built by default.
  localparam int SETS_MAX    = 1 << MAX_SET_BITS_DEF;
  localparam int WAYS_MAX    = MAX_WAYS_DEF;
  localparam int DIR_ENTRIES = SETS_MAX * WAYS_MAX;
  localparam int POOL_MAX    = 64;

  // The fourth command code has no name in the package; the block treats it
  // as a load.
  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

  localparam int ITEMS_PER_PHASE = 85;
  localparam int RANDOM_PHASES   = 10;

  // One expected result transaction.
  typedef struct packed {
    logic [OUTCOME_W-1:0] outcome;
    logic                 second_hit;
    logic [CNT_W-1:0]     hits;
    logic [CNT_W-1:0]     misses;
    logic [CNT_W-1:0]     evictions;
  } access_result_t;

  logic                 clk;
  logic                 rst_n          = 1'b0;
  logic                 in_valid       = 1'b0;
  logic                 in_ready;
  logic [CMD_W-1:0]     in_command     = CMD_LOAD;
  logic [IN_ADDR_W-1:0] in_mem_address = '0;
  logic                 out_valid;
  logic                 out_ready      = 1'b0;
  logic [OUTCOME_W-1:0] out_outcome;
  logic                 out_second_hit;
  logic [CNT_W-1:0]     out_hit_total;
  logic [CNT_W-1:0]     out_miss_total;
  logic [CNT_W-1:0]     out_eviction_total;
  logic                 psel           = 1'b0;
  logic                 penable        = 1'b0;
  logic                 pwrite         = 1'b0;
  logic [PADDR_W-1:0]   paddr          = '0;
  logic [DATA_W-1:0]    pwdata         = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  // When set, neither the access sender nor the result receiver idles.
  bit stall_free = 1'b0;
  int mismatch_count = 0;

  // Scoreboard copy of the configuration registers, raw as written.
  logic [2:0] cfg_set_bits;
  logic [4:0] cfg_block_bits;
  logic [3:0] cfg_ways;

  // Scoreboard copy of the tag directory and the running totals.
  logic             dir_valid [DIR_ENTRIES];
  logic [63:0]      dir_tag   [DIR_ENTRIES];
  logic [2:0]       dir_rank  [DIR_ENTRIES];
  logic [CNT_W-1:0] hit_cnt;
  logic [CNT_W-1:0] miss_cnt;
  logic [CNT_W-1:0] evict_cnt;

  access_result_t pending_results[$];

  set_assoc_cache_lru_sim uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_mem_address     (in_mem_address),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_outcome        (out_outcome),
    .out_second_hit     (out_second_hit),
    .out_hit_total      (out_hit_total),
    .out_miss_total     (out_miss_total),
    .out_eviction_total (out_eviction_total),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a handshake never completes. The slowest correct run is
  // well under a tenth of this.
  initial begin
    #3_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Scoreboard model
  // --------------------------------------------------------------------------

  // Register values above the built sizes act as the largest size, and a way
  // count of zero acts as one way.
  function automatic int eff_set_bits();
    return (cfg_set_bits > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : int'(cfg_set_bits);
  endfunction

  function automatic int eff_ways();
    if (cfg_ways == 0) return 1;
    return (cfg_ways > WAYS_MAX) ? WAYS_MAX : int'(cfg_ways);
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] count);
    return (count == '1) ? count : count + 1'b1;
  endfunction

  // Makes way w the most recently used. Every other valid way in use that
  // ranked more recent than w's old rank ages by one, up to the oldest rank.
  function automatic void refresh_rank(int base, int nw, int w, int old_rank);
    for (int v = 0; v < nw; v++) begin
      if (v != w && dir_valid[base+v] && dir_rank[base+v] < old_rank &&
          dir_rank[base+v] < WAYS_MAX - 1)
        dir_rank[base+v] = dir_rank[base+v] + 1'b1;
    end
    dir_rank[base+w] = '0;
  endfunction

  // One directory access: returns hit, fill or eviction and updates the
  // directory and the totals.
  function automatic logic [OUTCOME_W-1:0] lookup_line(logic [63:0] addr);
    int          sb;
    int          nw;
    int          base;
    int          victim;
    int          free_way;
    logic [2:0]  oldest;
    bit          found_free;
    logic [63:0] set_idx;
    logic [63:0] line;
    sb = eff_set_bits();
    nw = eff_ways();
    set_idx = (addr >> cfg_block_bits) & ((64'd1 << sb) - 64'd1);
    line = addr >> (int'(cfg_block_bits) + sb);
    base = int'(set_idx) * WAYS_MAX;
    for (int v = 0; v < nw; v++) begin
      if (dir_valid[base+v] && dir_tag[base+v] == line) begin
        refresh_rank(base, nw, v, int'(dir_rank[base+v]));
        hit_cnt = sat_inc(hit_cnt);
        return OUT_HIT;
      end
    end
    miss_cnt = sat_inc(miss_cnt);
    victim = 0;
    oldest = '0;
    found_free = 1'b0;
    free_way = 0;
    // Lowest invalid way wins; otherwise the oldest valid way, the lowest
    // index among equal ranks.
    for (int v = 0; v < nw; v++) begin
      if (!dir_valid[base+v]) begin
        if (!found_free) begin
          found_free = 1'b1;
          free_way = v;
        end
      end else if (v == 0 || dir_rank[base+v] > oldest) begin
        oldest = dir_rank[base+v];
        victim = v;
      end
    end
    if (found_free) begin
      dir_valid[base+free_way] = 1'b1;
      dir_tag[base+free_way] = line;
      refresh_rank(base, nw, free_way, WAYS_MAX);
      return OUT_FILL;
    end
    dir_tag[base+victim] = line;
    refresh_rank(base, nw, victim, int'(dir_rank[base+victim]));
    evict_cnt = sat_inc(evict_cnt);
    return OUT_EVICT;
  endfunction

  // Works out the result of one accepted access and queues it. A modify makes
  // a second access to the same line.
  function automatic void predict_access(logic [CMD_W-1:0] cmd, logic [63:0] addr);
    access_result_t res;
    res.outcome = lookup_line(addr);
    res.second_hit = 1'b0;
    if (cmd == CMD_MODIFY)
      res.second_hit = (lookup_line(addr) == OUT_HIT);
    res.hits = hit_cnt;
    res.misses = miss_cnt;
    res.evictions = evict_cnt;
    pending_results.push_back(res);
  endfunction

  function automatic void clear_model();
    cfg_set_bits = SET_BITS_RST;
    cfg_block_bits = BLOCK_BITS_RST;
    cfg_ways = WAYS_RST;
    for (int e = 0; e < DIR_ENTRIES; e++) begin
      dir_valid[e] = 1'b0;
      dir_tag[e] = '0;
      dir_rank[e] = '0;
    end
    hit_cnt = '0;
    miss_cnt = '0;
    evict_cnt = '0;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random back-pressure and the in-order checker
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    out_ready <= stall_free || ($urandom_range(0, 99) >= 14);
  end

  function automatic void check_field(string field, logic [CNT_W-1:0] want,
                                      logic [CNT_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, field, want, got);
    end
  endfunction

  // Every result transaction is matched against the oldest expectation.
  always @(posedge clk) begin : result_checker
    access_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result transaction with nothing expected, expected none, actual %0h",
                 $realtime, out_outcome);
      end else begin
        want = pending_results.pop_front();
        check_field("outcome", CNT_W'(want.outcome), CNT_W'(out_outcome));
        check_field("second_hit", CNT_W'(want.second_hit), CNT_W'(out_second_hit));
        check_field("hit_total", want.hits, out_hit_total);
        check_field("miss_total", want.misses, out_miss_total);
        check_field("eviction_total", want.evictions, out_eviction_total);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Access side and register port
  // --------------------------------------------------------------------------

  // Presents one access and holds it until it is accepted. Valid is left high
  // on return so that a following access can go out back to back; the idle
  // loop of the next call or drain_results lowers it.
  task automatic send_access(logic [CMD_W-1:0] cmd, logic [63:0] addr);
    while (!stall_free && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_mem_address <= addr;
    do @(posedge clk); while (!in_ready);
    predict_access(cmd, addr);
  endtask

  // Waits for every expected result, then lets the pipeline settle before the
  // registers may be touched.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One APB write: setup cycle, then access cycle until pready. The bits above
  // the field are filled with noise; the register keeps only its own width.
  task automatic write_reg(logic [1:0] idx, logic [4:0] value);
    logic [DATA_W-1:0] noise;
    logic [DATA_W-1:0] data;
    noise = $urandom;
    case (idx)
      REG_SET_BITS:   data = {noise[DATA_W-1:3], value[2:0]};
      REG_BLOCK_BITS: data = {noise[DATA_W-1:5], value[4:0]};
      default:        data = {noise[DATA_W-1:4], value[3:0]};
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_SET_BITS:   cfg_set_bits = value[2:0];
      REG_BLOCK_BITS: cfg_block_bits = value[4:0];
      default:        cfg_ways = value[3:0];
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(logic [2:0] sb, logic [4:0] bb, logic [3:0] nw);
    drain_results();
    write_reg(REG_SET_BITS, {2'b00, sb});
    write_reg(REG_BLOCK_BITS, bb);
    write_reg(REG_WAYS, {1'b0, nw});
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Register defaults after reset: 16 sets, 16-byte blocks, direct mapped.
  // Covers fill, hit inside a block, eviction, modify and the reserved command,
  // and the lowest and highest addresses.
  task automatic test_reset_defaults();
    send_access(CMD_LOAD, 64'h0);
    send_access(CMD_LOAD, 64'hF);
    send_access(CMD_STORE, 64'h10);
    send_access(CMD_MODIFY, 64'h100);
    send_access(CMD_RESERVED, 64'h108);
    send_access(CMD_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(CMD_STORE, 64'h8000_0000_0000_00F0);
    send_access(CMD_MODIFY, 64'hFFFF_FFFF_FFFF_FFF0);
  endtask

  // One set of four ways with byte-sized blocks, so the tag is the address.
  // The sequence fills all ways, refreshes one and then forces several LRU
  // evictions so the victim order is exercised.
  task automatic test_lru_replacement();
    apply_config(3'd0, 5'd0, 4'd4);
    send_access(CMD_LOAD, 64'h1001);
    send_access(CMD_LOAD, 64'h1002);
    send_access(CMD_STORE, 64'h1003);
    send_access(CMD_LOAD, 64'h1004);
    send_access(CMD_LOAD, 64'h1001);
    send_access(CMD_LOAD, 64'h1005);
    send_access(CMD_MODIFY, 64'h1002);
    send_access(CMD_STORE, 64'h1004);
    send_access(CMD_LOAD, 64'h1006);
  endtask

  // Register values beyond the built sizes: set bits above the maximum, the
  // widest block offset, a way count above the maximum and a way count of zero.
  task automatic test_clamped_fields();
    apply_config(3'd7, 5'd31, 4'd15);
    send_access(CMD_LOAD, 64'h0);
    send_access(CMD_LOAD, 64'h0000_001F_8000_0000);
    send_access(CMD_MODIFY, 64'hFFFF_FFE0_7FFF_FFFF);
    send_access(CMD_STORE, 64'h0000_0000_7FFF_FFFF);
    apply_config(3'd6, 5'd0, 4'd0);
    send_access(CMD_LOAD, 64'h0000_0000_0000_0040);
    send_access(CMD_LOAD, 64'h0000_0000_0000_0080);
    send_access(CMD_MODIFY, 64'h0000_0000_0000_0040);
  endtask

  // Random traffic in phases, each under its own register setting. The
  // directory is never cleared between phases, so stale lines from earlier
  // settings stay in play. Within a phase most accesses come from a small
  // pool of lines packed into a few sets, which keeps the ways under pressure
  // and gives a mix of hits, fills and evictions; the rest are random
  // addresses. Two phases in the middle run with no idling on either side.
  task automatic test_random_traffic();
    logic [63:0] line_pool[POOL_MAX];
    logic [63:0] addr;
    logic [63:0] tag_bits;
    logic [CMD_W-1:0] cmd;
    int pool_n;
    int sets;
    int nsets;
    int set_base;
    int shift;
    int pick;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       apply_config(3'd0, 5'd0, 4'd8);
        1:       apply_config(3'd7, 5'd31, 4'd15);
        2:       apply_config(3'd6, 5'd16, 4'd0);
        3:       apply_config(3'd1, 5'd3, 4'd1);
        default: apply_config(3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                              4'($urandom_range(0, 15)));
      endcase
      stall_free = (phase == 5 || phase == 6);
      sets = 1 << eff_set_bits();
      nsets = $urandom_range(1, (sets < 4) ? sets : 4);
      set_base = $urandom_range(0, sets - nsets);
      pool_n = $urandom_range(1, (3 * eff_ways() * nsets > POOL_MAX) ?
                                 POOL_MAX : 3 * eff_ways() * nsets);
      shift = int'(cfg_block_bits) + eff_set_bits();
      for (int i = 0; i < pool_n; i++) begin
        tag_bits = {$urandom, $urandom};
        line_pool[i] = (tag_bits << shift) |
                       (64'(set_base + $urandom_range(0, nsets - 1)) << cfg_block_bits);
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 35)      cmd = CMD_LOAD;
        else if (pick < 65) cmd = CMD_STORE;
        else if (pick < 90) cmd = CMD_MODIFY;
        else                cmd = CMD_RESERVED;
        addr = {$urandom, $urandom};
        if ($urandom_range(0, 99) >= 12)
          addr = line_pool[$urandom_range(0, pool_n - 1)] |
                 (addr & ((64'd1 << cfg_block_bits) - 64'd1));
        send_access(cmd, addr);
      end
    end
    stall_free = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    clear_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_lru_replacement();
    test_clamped_fields();
    test_random_traffic();
    drain_results();

    if (mismatch_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
